// ----- rtl/dtof_pkg.sv -----
// Package for the double-sided two-way ranging time-of-flight block.
// Holds the default interval width, the fixed field widths of the ports and the queue depth and pointer width.
// No dependencies.
package dtof_pkg;

  localparam int INTERVAL_BITS_DEF = 32;
  localparam int TS_LONG_BITS      = 40;
  localparam int TS_SHORT_BITS     = 32;
  localparam int IN_DATA_BITS      = 3 * TS_LONG_BITS + 3 * TS_SHORT_BITS;
  localparam int FLIGHT_BITS       = 32;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_BITS    = 2;

endpackage

// ----- rtl/dtof_front.sv -----
// Front part: forms the four intervals, the two products, their magnitude
// difference and the interval sum. Depends on dtof_pkg.
module dtof_front #(
  parameter int INTERVAL_BITS = dtof_pkg::INTERVAL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dtof_pkg::TS_LONG_BITS-1:0]  poll_rx_time,
  input  logic [dtof_pkg::TS_LONG_BITS-1:0]  resp_sent_time,
  input  logic [dtof_pkg::TS_LONG_BITS-1:0]  final_rx_time,
  input  logic [dtof_pkg::TS_SHORT_BITS-1:0] poll_tx_time,
  input  logic [dtof_pkg::TS_SHORT_BITS-1:0] resp_rx_time,
  input  logic [dtof_pkg::TS_SHORT_BITS-1:0] final_tx_time,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [2*INTERVAL_BITS-1:0]       num,
  output logic [INTERVAL_BITS+1:0]         den
);
  import dtof_pkg::*;

  localparam int IB = INTERVAL_BITS;
  localparam int NW = 2 * IB;
  localparam int DW = IB + 2;

  logic          a_valid;
  logic [IB-1:0] reply1, reply2, round1, round2;
  logic          b_valid;
  logic [NW-1:0] prod_reply, prod_round;
  logic [DW-1:0] den_b;
  logic          en;

  // advance unless the product stage holds a word the queue cannot take
  assign en       = !b_valid || !q_full;
  assign in_ready = en;
  assign q_push   = b_valid && !q_full;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  // wrapping intervals, then products and sum
  always_ff @(posedge clk) begin
    if (en) begin
      reply1     <= resp_sent_time[IB-1:0] - poll_rx_time[IB-1:0];
      reply2     <= final_tx_time[IB-1:0]  - resp_rx_time[IB-1:0];
      round1     <= resp_rx_time[IB-1:0]   - poll_tx_time[IB-1:0];
      round2     <= final_rx_time[IB-1:0]  - resp_sent_time[IB-1:0];
      prod_reply <= NW'(reply1) * NW'(reply2);
      prod_round <= NW'(round1) * NW'(round2);
      den_b      <= DW'(reply1) + DW'(reply2) + DW'(round1) + DW'(round2);
    end
  end

  // magnitude of the product difference
  assign num = (prod_reply >= prod_round) ? (prod_reply - prod_round)
                                          : (prod_round - prod_reply);
  assign den = den_b;

endmodule

// ----- rtl/dtof_queue.sv -----
// Short queue between front and back parts, one word per entry.
// Depends on dtof_pkg.
module dtof_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] rdata
);
  import dtof_pkg::*;

  logic [WIDTH-1:0]          slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_pop;

  assign full       = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign rdata      = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(do_pop);
    end
  end

  // store word
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule

// ----- rtl/dtof_div.sv -----
// Back part: pipelined restoring divider, one quotient bit per stage.
// Depends on dtof_pkg.
module dtof_div #(
  parameter int INTERVAL_BITS = dtof_pkg::INTERVAL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  output logic                               pop,
  input  logic [2*INTERVAL_BITS-1:0]         num,
  input  logic [INTERVAL_BITS+1:0]           den,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dtof_pkg::FLIGHT_BITS-1:0]   flight_ticks,
  output logic                               zero_divisor
);
  import dtof_pkg::*;

  localparam int IB = INTERVAL_BITS;
  localparam int DW = IB + 2;

  logic          vld [1:IB];
  logic [DW-1:0] rem [1:IB];
  logic [IB-1:0] low [1:IB];
  logic [IB-1:0] quo [1:IB];
  logic [DW-1:0] dn  [1:IB];
  logic          en;

  // advance unless the last stage holds a word not yet taken
  assign en  = !(vld[IB] && !out_ready);
  assign pop = head_valid && en;

  for (genvar i = 1; i <= IB; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [IB-1:0] l_in;
    logic [IB-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 1) begin : g_head
      // first stage: high half of the numerator is already below the divisor
      assign v_in = head_valid;
      assign r_in = DW'(num[2*IB-1:IB]);
      assign l_in = num[IB-1:0];
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_prev
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign l_in = low[i-1];
      assign q_in = quo[i-1];
      assign d_in = dn[i-1];
    end

    // shift in one numerator bit and try a subtract
    always_comb begin
      sh   = {r_in, l_in[IB-1]};
      diff = sh - {1'b0, d_in};
      ge   = !diff[DW];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else if (en) vld[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        low[i] <= {l_in[IB-2:0], 1'b0};
        quo[i] <= {q_in[IB-2:0], ge};
        dn[i]  <= d_in;
      end
    end
  end

  // last stage is the output register
  assign out_valid    = vld[IB];
  assign zero_divisor = (dn[IB] == '0);
  assign flight_ticks = zero_divisor ? '0 : FLIGHT_BITS'(quo[IB]);

endmodule

// ----- rtl/ds_twr_time_of_flight.sv -----
// Top level of the double-sided two-way ranging time-of-flight block.
// Instantiates dtof_front, dtof_queue and dtof_div; depends on dtof_pkg.
//
// Usage:
//   The slave stream takes one word per ranging exchange carrying the six
//   timestamps; the master stream returns one word per exchange with the
//   one-way flight time in ticks and a zero-divisor flag in tuser.
//   From acceptance to result, a word passes these registers in order: the
//   intervals, which load at the accepting edge, then the products, then
//   the queue entry, then one divider stage per quotient bit, the last of
//   which is the output register.
//   Throughput is one word per cycle while the receiver keeps up; the divider
//   pipeline takes a new word every cycle it advances.
//   When the receiver stalls, the divider pipeline holds, the four-entry
//   queue fills, and then the front stops and s_tready drops.
//   Reset (synchronous, rst high) empties all stages and the queue; s_tready
//   is high in the cycle after reset.
module ds_twr_time_of_flight #(
  parameter int INTERVAL_BITS = dtof_pkg::INTERVAL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // low to high: poll_rx_time[40], resp_sent_time[40], final_rx_time[40],
  //              poll_tx_time[32], resp_rx_time[32], final_tx_time[32]
  input  logic [dtof_pkg::IN_DATA_BITS-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // low to high: flight_ticks[32]
  output logic [dtof_pkg::FLIGHT_BITS-1:0]  m_tdata,
  // low to high: zero_divisor[1]
  output logic                              m_tuser
);
  import dtof_pkg::*;

  localparam int NW = 2 * INTERVAL_BITS;
  localparam int DW = INTERVAL_BITS + 2;

  logic          q_full, q_push, q_pop, q_valid;
  logic [NW-1:0] f_num, h_num;
  logic [DW-1:0] f_den, h_den;

  dtof_front #(.INTERVAL_BITS(INTERVAL_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .poll_rx_time   (s_tdata[39:0]),
    .resp_sent_time (s_tdata[79:40]),
    .final_rx_time  (s_tdata[119:80]),
    .poll_tx_time   (s_tdata[151:120]),
    .resp_rx_time   (s_tdata[183:152]),
    .final_tx_time  (s_tdata[215:184]),
    .q_full         (q_full),
    .q_push         (q_push),
    .num            (f_num),
    .den            (f_den)
  );

  dtof_queue #(.WIDTH(NW + DW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .wdata      ({f_den, f_num}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .rdata      ({h_den, h_num})
  );

  dtof_div #(.INTERVAL_BITS(INTERVAL_BITS)) u_div (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_valid),
    .pop          (q_pop),
    .num          (h_num),
    .den          (h_den),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .flight_ticks (m_tdata),
    .zero_divisor (m_tuser)
  );

endmodule

// ----- rtl/dtof_checker.sv -----
// Port-level checks for ds_twr_time_of_flight, attached by bind.
// Depends on dtof_pkg.
module dtof_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [dtof_pkg::FLIGHT_BITS-1:0] m_tdata,
  input logic                             m_tuser
);
  import dtof_pkg::*;

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // front is ready after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // zero divisor forces a zero result
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("nonzero result with zero divisor");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output word changed");

endmodule

bind ds_twr_time_of_flight dtof_checker u_dtof_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/ds_twr_time_of_flight_tb.sv -----
// Testbench for ds_twr_time_of_flight: drives ranging exchanges on the slave
// stream and checks each master word against a built-in flight-time predictor.
// Depends on dtof_pkg and the RTL of ds_twr_time_of_flight.
`timescale 1ns / 100ps

module ds_twr_time_of_flight_tb;
  import dtof_pkg::*;

  localparam int IVB = INTERVAL_BITS_DEF;
  localparam int LAT = IVB + 3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [TS_SHORT_BITS-1:0] final_tx;
    logic [TS_SHORT_BITS-1:0] resp_rx;
    logic [TS_SHORT_BITS-1:0] poll_tx;
    logic [TS_LONG_BITS-1:0]  final_rx;
    logic [TS_LONG_BITS-1:0]  resp_tx;
    logic [TS_LONG_BITS-1:0]  poll_rx;
  } exchange_t;

  typedef struct packed {
    logic [FLIGHT_BITS-1:0] ticks;
    logic                   zero_div;
  } flight_t;

  // Scoreboard: predicts the flight time of each exchange and checks results
  class flight_board;
    flight_t pending[$];
    int errors = 0;

    function logic [63:0] span(logic [63:0] later, logic [63:0] earlier);
      logic [63:0] mask;
      mask = (64'd1 << IVB) - 64'd1;
      return ((later & mask) - (earlier & mask)) & mask;
    endfunction

    function void note_exchange(exchange_t x);
      logic [63:0] r1, r2, t1, t2, pr, pt, num, den;
      flight_t f;
      r1 = span(x.resp_tx, x.poll_rx);
      r2 = span(x.final_tx, x.resp_rx);
      t1 = span(x.resp_rx, x.poll_tx);
      t2 = span(x.final_rx, x.resp_tx);
      pr = r1 * r2;
      pt = t1 * t2;
      num = (pr >= pt) ? pr - pt : pt - pr;
      den = r1 + r2 + t1 + t2;
      if (den == 0) begin
        f.ticks = '0;
        f.zero_div = 1'b1;
      end else begin
        f.ticks = FLIGHT_BITS'(num / den);
        f.zero_div = 1'b0;
      end
      pending.push_back(f);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_flight(logic [FLIGHT_BITS-1:0] ticks, logic zero_div);
      flight_t f;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word ticks=%0d", ticks));
      end else begin
        f = pending.pop_front();
        if (ticks !== f.ticks)
          report($sformatf("flight_ticks got %0d want %0d", ticks, f.ticks));
        if (zero_div !== f.zero_div)
          report($sformatf("zero_divisor got %0b want %0b", zero_div, f.zero_div));
      end
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [IN_DATA_BITS-1:0] s_tdata;
  logic [FLIGHT_BITS-1:0] m_tdata;
  bit calm;
  int cycles;
  flight_board board;

  ds_twr_time_of_flight u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check master words and count cycles against the limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) board.check_flight(m_tdata, m_tuser);
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts unless calm
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Send one exchange word and hold it until accepted; valid stays high
  task send_exchange(exchange_t x);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_exchange(x);
    @(negedge clk);
  endtask

  // Build a plausible exchange: consistent timestamps with random offsets
  function exchange_t plausible();
    exchange_t x;
    logic [31:0] tof, d1, d2, b;
    tof = $urandom_range(0, 2000);
    d1 = $urandom_range(0, 1 << 20);
    d2 = $urandom_range(0, 1 << 20);
    b = $urandom();
    x.poll_tx = $urandom();
    x.resp_rx = x.poll_tx + 2 * tof + d1 + $urandom_range(0, 50);
    x.final_tx = x.resp_rx + d2;
    x.poll_rx = {8'($urandom()), b};
    x.resp_tx = {8'($urandom()), b + d1};
    x.final_rx = {8'($urandom()), b + d1 + 2 * tof + d2 + $urandom_range(0, 50)};
    return x;
  endfunction

  function exchange_t noise();
    exchange_t x;
    x.poll_rx = {8'($urandom()), 32'($urandom())};
    x.resp_tx = {8'($urandom()), 32'($urandom())};
    x.final_rx = {8'($urandom()), 32'($urandom())};
    x.poll_tx = $urandom();
    x.resp_rx = $urandom();
    x.final_tx = $urandom();
    return x;
  endfunction

  initial begin
    exchange_t x;
    board = new();
    cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero divisor, all ones, wrap, and extreme intervals
    send_exchange('0);
    send_exchange('1);
    x = '0; x.poll_rx = 40'hFF_0000_0000; x.resp_tx = 40'h00_0000_0000;
    send_exchange(x);
    x = '0; x.resp_tx = 40'hFF_FFFF_FFFF; x.final_tx = '1;
    send_exchange(x);
    x = '0; x.resp_rx = '1; x.final_rx = 40'h00_FFFF_FFFF;
    send_exchange(x);
    x = '0; x.resp_tx = 40'h00_FFFF_FFFF; x.final_tx = '1; x.resp_rx = '1;
    x.final_rx = 40'h00_FFFF_FFFE;
    send_exchange(x);
    x = '0; x.poll_tx = 32'hFFFF_FFF0; x.resp_rx = 32'h0000_0100;
    x.final_tx = 32'h0000_0200; x.poll_rx = 40'hAB_FFFF_FF80;
    x.resp_tx = 40'h12_0000_0070; x.final_rx = 40'h00_0000_0180;
    send_exchange(x);
    x = '1; x.poll_tx = '0;
    send_exchange(x);
    for (int i = 0; i < 12; i++) send_exchange(i % 2 ? noise() : plausible());

    // Drain fully before continuing
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);

    // Random part: mostly consistent exchanges, some noise
    for (int i = 0; i < 530; i++) begin
      if (i == 430) calm = 1'b1;
      send_exchange($urandom_range(0, 3) != 0 ? plausible() : noise());
    end

    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
